[rtl/core/byte_ring_buffer_unit_defines.svh]
// Assertion macros shared by the byte ring buffer checker.
// No dependencies.
`ifndef BYTE_RING_BUFFER_UNIT_DEFINES_SVH
`define BYTE_RING_BUFFER_UNIT_DEFINES_SVH
`define BRB_ASSERT_IMPL(lbl, clk, rst, prop, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);
`define BRB_ASSERT_NORST(lbl, clk, prop, msg) \
   lbl: assert property (@(posedge clk) prop) else $error(msg);
`endif

[rtl/core/brb_pkg.sv]
// Package for the byte ring buffer: command codes and the state type.
// No dependencies.
`timescale 1ns / 1ps
package brb_pkg;
   localparam logic [2:0] OP_ENQ   = 3'd0;
   localparam logic [2:0] OP_DEQ   = 3'd1;
   localparam logic [2:0] OP_PEEK  = 3'd2;
   localparam logic [2:0] OP_ADVW  = 3'd3;
   localparam logic [2:0] OP_ADVR  = 3'd4;
   localparam logic [2:0] OP_CLEAR = 3'd5;

   typedef enum logic [3:0] {
      ST_IDLE  = 4'b0001,
      ST_PASS1 = 4'b0010,
      ST_PASS2 = 4'b0100,
      ST_DONE  = 4'b1000
   } state_type;
endpackage

[rtl/core/brb_lane.sv]
// One byte bank of the ring buffer: stores every LANES-th byte.
// Depends on nothing but its parameters.
`timescale 1ns / 1ps
module brb_lane #(
   parameter int ROWS = 512
) (
   input  logic                    clock,
   input  logic                    wr_en,
   input  logic [$clog2(ROWS)-1:0] wr_row,
   input  logic [7:0]              wr_data,
   input  logic [$clog2(ROWS)-1:0] rd_row,
   output logic [7:0]              rd_data
);
   logic [7:0] mem [ROWS];
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_row] <= wr_data;
      end
      rd_data <= mem[rd_row];
   end
endmodule

[rtl/core/byte_ring_buffer_unit.sv]
// Top level of the byte ring buffer: eight byte banks, pointer control and the
// byte merge stage. Depends on brb_pkg and brb_lane.
// Each request taken in ST_IDLE steps through ST_PASS1 and ST_PASS2, two bank passes
// that split a transfer at the wrap point, then ST_DONE with the result strobe. busy is
// held until ST_IDLE; no new request is taken before then. Reset (synchronous)
// zeroes both pointers and sets the size to DEPTH; the store is kept. No receiver stall.
`timescale 1ns / 1ps
module byte_ring_buffer_unit #(
   parameter int DEPTH     = 4096,
   parameter int MAX_BYTES = 8
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        csr_write_enable,
   input  logic [12:0] csr_buffer_size,
   input  logic        start,
   output logic        busy,
   input  logic [2:0]  req_operation,
   input  logic [12:0] req_amount,
   input  logic [63:0] req_write_bytes,
   output logic        rsp_valid,
   output logic [12:0] rsp_done_count,
   output logic [63:0] rsp_read_bytes,
   output logic [11:0] rsp_used_size,
   output logic [11:0] rsp_free_size,
   output logic [11:0] rsp_direct_write_span,
   output logic [11:0] rsp_direct_read_span
);
   import brb_pkg::*;
   localparam int LANES = 8;
   localparam int LB = 3;
   localparam int PW = $clog2(DEPTH) + 1;
   localparam int ROWS = (DEPTH + LANES - 1) / LANES;
   localparam int RW = (ROWS > 1) ? $clog2(ROWS) : 1;

   state_type state_ff, state_in;
   logic [PW-1:0] size_ff, size_in, rp_ff, rp_in, wp_ff, wp_in;
   logic [PW-1:0] base_ff, base_in;
   logic [12:0] done_ff, done_in;
   logic [3:0]  xfer_ff, xfer_in;
   logic        wr_ff, wr_in, rdop_ff, rdop_in;
   logic [63:0] wdata_ff, wdata_in, rdata_ff, rdata_in;
   logic [PW-1:0] used, freeb, used_n, free_n;
   logic [PW:0] sum_a;
   logic fit, okw, okr, okm;
   logic [PW-1:0] addr [LANES];
   logic [LANES-1:0] wrapped, act, got;
   logic [7:0] rd [LANES];
   logic [63:0] rbytes;

   function automatic logic [PW-1:0] wadd(input logic [PW-1:0] p,
                                          input logic [PW:0] n,
                                          input logic [PW-1:0] s);
      logic [PW:0] q;
      q = {1'b0, p} + n;
      if (q >= {1'b0, s}) q = q - {1'b0, s};
      return q[PW-1:0];
   endfunction

   always_comb begin
      if (csr_buffer_size < 13'd2) size_in = PW'(2);
      else if ({19'd0, csr_buffer_size} > 32'(DEPTH)) size_in = PW'(DEPTH);
      else size_in = PW'(csr_buffer_size);
   end

   assign used  = (rp_ff > wp_ff) ? size_ff - rp_ff + wp_ff : wp_ff - rp_ff;
   assign freeb = size_ff - used - PW'(1);
   assign fit   = ({19'd0, req_amount} <= 32'(MAX_BYTES));
   assign okw   = fit && ({19'd0, req_amount} <= 32'(freeb));
   assign okr   = fit && ({19'd0, req_amount} <= 32'(used));
   assign okm   = ({19'd0, req_amount} <= 32'(size_ff));
   assign sum_a = (PW+1)'(req_amount);

   for (genvar g = 0; g < LANES; g++) begin : g_lane
      logic [PW:0] q;
      logic        live;
      assign q = {1'b0, base_ff} + (PW+1)'(g);
      assign wrapped[g] = (q >= {1'b0, size_ff});
      assign addr[g] = wrapped[g] ? PW'(q - {1'b0, size_ff}) : q[PW-1:0];
      assign live = (4'(g) < xfer_ff);
      assign act[g] = live && ((state_ff == ST_PASS1 && !wrapped[g])
                               || (state_ff == ST_PASS2 && wrapped[g]));
      assign got[g] = live && rdop_ff && ((state_ff == ST_PASS2 && !wrapped[g])
                                          || (state_ff == ST_DONE && wrapped[g]));
   end

   for (genvar b = 0; b < LANES; b++) begin : g_bank
      logic [RW-1:0] row;
      logic          wen;
      logic [7:0]    wdat;
      always_comb begin
         wen = 1'b0; row = '0; wdat = '0;
         for (int g = 0; g < LANES; g++) begin
            if (act[g] && addr[g][LB-1:0] == LB'(b)) begin
               wen = wr_ff; row = RW'(addr[g] >> LB); wdat = wdata_ff[8*g +: 8];
            end
         end
      end
      brb_lane #(.ROWS(1 << RW)) u_lane (
         .clock(clock), .wr_en(wen), .wr_row(row), .wr_data(wdat),
         .rd_row(row), .rd_data(rd[b]));
   end

   always_comb begin
      rbytes = rdata_ff;
      for (int g = 0; g < LANES; g++) begin
         if (got[g]) rbytes[8*g +: 8] = rd[addr[g][LB-1:0]];
      end
   end

   always_comb begin
      state_in = state_ff; rp_in = rp_ff; wp_in = wp_ff; done_in = done_ff;
      base_in = base_ff; xfer_in = xfer_ff; wr_in = wr_ff; rdop_in = rdop_ff;
      wdata_in = wdata_ff; rdata_in = rdata_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (start) begin
               state_in = ST_PASS1;
               done_in = '0; xfer_in = '0; wr_in = 1'b0; rdop_in = 1'b0;
               base_in = wp_ff; wdata_in = req_write_bytes; rdata_in = '0;
               unique case (req_operation)
                  OP_ENQ: if (okw) begin
                     wp_in = wadd(wp_ff, sum_a, size_ff); done_in = req_amount;
                     xfer_in = 4'(req_amount); wr_in = 1'b1;
                  end
                  OP_DEQ, OP_PEEK: begin
                     base_in = rp_ff; rdop_in = 1'b1;
                     if (okr) begin
                        done_in = req_amount; xfer_in = 4'(req_amount);
                        if (req_operation == OP_DEQ) rp_in = wadd(rp_ff, sum_a, size_ff);
                     end
                  end
                  OP_ADVW: if (okm) begin
                     wp_in = wadd(wp_ff, sum_a, size_ff); done_in = req_amount;
                  end
                  OP_ADVR: if (okm) begin
                     rp_in = wadd(rp_ff, sum_a, size_ff); done_in = req_amount;
                  end
                  OP_CLEAR: begin
                     rp_in = '0; wp_in = '0;
                  end
                  default: ;
               endcase
            end
         end
         ST_PASS1: state_in = ST_PASS2;
         ST_PASS2: begin
            state_in = ST_DONE; rdata_in = rbytes;
         end
         ST_DONE: state_in = ST_IDLE;
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE; rp_ff <= '0; wp_ff <= '0; size_ff <= PW'(DEPTH);
      end else if (csr_write_enable) begin
         size_ff <= size_in; rp_ff <= '0; wp_ff <= '0;
      end else begin
         state_ff <= state_in; rp_ff <= rp_in; wp_ff <= wp_in;
      end
      done_ff  <= done_in;
      base_ff  <= base_in;
      xfer_ff  <= xfer_in;
      wr_ff    <= wr_in;
      rdop_ff  <= rdop_in;
      wdata_ff <= wdata_in;
      rdata_ff <= rdata_in;
   end

   assign used_n = (rp_ff > wp_ff) ? size_ff - rp_ff + wp_ff : wp_ff - rp_ff;
   assign free_n = size_ff - used_n - PW'(1);
   assign busy = (state_ff != ST_IDLE);
   assign rsp_valid = (state_ff == ST_DONE);
   assign rsp_done_count = done_ff;
   assign rsp_read_bytes = rdop_ff ? rbytes : 64'd0;
   assign rsp_used_size = 12'(used_n);
   assign rsp_free_size = 12'(free_n);
   assign rsp_direct_write_span = 12'((wp_ff >= rp_ff) ?
      ((rp_ff == 0) ? size_ff - wp_ff - PW'(1) : size_ff - wp_ff) : free_n);
   assign rsp_direct_read_span = 12'((wp_ff < rp_ff) ? size_ff - rp_ff : used_n);
endmodule

[rtl/core/brb_checker.sv]
// Port checker for the byte ring buffer, bound to the top level.
// Depends on byte_ring_buffer_unit_defines.svh.
`timescale 1ns / 1ps
`include "byte_ring_buffer_unit_defines.svh"
module brb_checker (
   input logic        clock,
   input logic        reset,
   input logic        start,
   input logic        busy,
   input logic        rsp_valid,
   input logic [11:0] rsp_used_size,
   input logic [11:0] rsp_free_size
);
   `BRB_ASSERT_IMPL(a_busy_after_start, clock, reset, start && !busy |=> busy, "no busy")
   `BRB_ASSERT_IMPL(a_valid_busy, clock, reset, rsp_valid |-> busy, "valid idle")
   `BRB_ASSERT_IMPL(a_one_strobe, clock, reset, rsp_valid |=> !rsp_valid, "double")
   `BRB_ASSERT_IMPL(a_room_sum, clock, reset, rsp_valid |-> (({1'b0, rsp_used_size} + {1'b0, rsp_free_size}) <= 13'd4095), "room")
   `BRB_ASSERT_NORST(a_reset_idle, clock, reset |=> !busy, "reset busy")
endmodule

bind byte_ring_buffer_unit brb_checker u_brb_checker (.*);

[tb/byte_ring_buffer_unit_tb.sv]
// Self-checking testbench for the byte ring buffer: a queued request driver, a result
// monitor and a cycle-free predictor of the FIFO. Depends on brb_pkg and the RTL top level.
`timescale 1ns / 1ps
module byte_ring_buffer_unit_tb;
   import brb_pkg::*;

   localparam int          STORE_DEPTH  = 4096;
   localparam int          LANES        = 8;
   localparam logic [2:0]  OP_SPARE_LO  = 3'd6;
   localparam logic [2:0]  OP_SPARE_HI  = 3'd7;

   typedef struct {
      logic [2:0]  operation;
      logic [12:0] amount;
      logic [63:0] write_bytes;
   } request_type;

   typedef struct {
      logic [12:0] done_count;
      logic [63:0] read_bytes;
      logic [11:0] used_size;
      logic [11:0] free_size;
      logic [11:0] direct_write_span;
      logic [11:0] direct_read_span;
   } reply_type;

   typedef struct {
      logic [7:0]  bytes[STORE_DEPTH];
      bit          written[STORE_DEPTH];
      int unsigned rd_ptr;
      int unsigned wr_ptr;
      logic [12:0] size_reg;
   } fifo_type;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        csr_write_enable = 1'b0;
   logic [12:0] csr_buffer_size = '0;
   logic        start = 1'b0;
   logic        busy;
   logic [2:0]  req_operation = '0;
   logic [12:0] req_amount = '0;
   logic [63:0] req_write_bytes = '0;
   logic        rsp_valid;
   logic [12:0] rsp_done_count;
   logic [63:0] rsp_read_bytes;
   logic [11:0] rsp_used_size;
   logic [11:0] rsp_free_size;
   logic [11:0] rsp_direct_write_span;
   logic [11:0] rsp_direct_read_span;

   request_type pending_requests[$];
   reply_type   expected_replies[$];
   fifo_type    plan_fifo;
   fifo_type    model_fifo;
   int          idle_percent = 0;
   int          fail_count = 0;

   byte_ring_buffer_unit u_top (.*);

   always #10 clock = ~clock;

   function automatic int unsigned active_slots(fifo_type f);
      if (f.size_reg < 2) return 2;
      if (f.size_reg > STORE_DEPTH) return STORE_DEPTH;
      return 32'(f.size_reg);
   endfunction

   function automatic int unsigned stored_count(fifo_type f, int unsigned s);
      if (f.rd_ptr > f.wr_ptr) return s - f.rd_ptr + f.wr_ptr;
      return f.wr_ptr - f.rd_ptr;
   endfunction

   function automatic void fifo_step(inout fifo_type f, input request_type r,
                                     output reply_type y);
      int unsigned s, used, room, amt, done, dws, drs;
      logic [63:0] data;
      s = active_slots(f);
      used = stored_count(f, s);
      room = s - used - 1;
      amt = 32'(r.amount);
      done = 0;
      data = '0;
      case (r.operation)
         OP_ENQ: begin
            if (amt <= LANES && amt <= room) begin
               for (int i = 0; i < amt; i++) begin
                  f.bytes[(f.wr_ptr + i) % s] = r.write_bytes[8*i +: 8];
                  f.written[(f.wr_ptr + i) % s] = 1'b1;
               end
               f.wr_ptr = (f.wr_ptr + amt) % s;
               done = amt;
            end
         end
         OP_DEQ, OP_PEEK: begin
            if (amt <= LANES && amt <= used) begin
               for (int i = 0; i < amt; i++)
                  data[8*i +: 8] = f.bytes[(f.rd_ptr + i) % s];
               if (r.operation == OP_DEQ) f.rd_ptr = (f.rd_ptr + amt) % s;
               done = amt;
            end
         end
         OP_ADVW: begin
            if (amt <= s) begin
               f.wr_ptr = (f.wr_ptr + amt) % s;
               done = amt;
            end
         end
         OP_ADVR: begin
            if (amt <= s) begin
               f.rd_ptr = (f.rd_ptr + amt) % s;
               done = amt;
            end
         end
         OP_CLEAR: begin
            f.rd_ptr = 0;
            f.wr_ptr = 0;
         end
         default: ;
      endcase
      used = stored_count(f, s);
      room = s - used - 1;
      if (f.wr_ptr >= f.rd_ptr) dws = (f.rd_ptr == 0) ? s - f.wr_ptr - 1 : s - f.wr_ptr;
      else dws = room;
      drs = (f.wr_ptr < f.rd_ptr) ? s - f.rd_ptr : used;
      y.done_count = 13'(done);
      y.read_bytes = data;
      y.used_size = 12'(used);
      y.free_size = 12'(room);
      y.direct_write_span = 12'(dws);
      y.direct_read_span = 12'(drs);
   endfunction

   // A read that would touch bytes never written since reset is turned into a read
   // pointer advance over the same distance.
   task automatic queue_request(logic [2:0] op, logic [12:0] amt, logic [63:0] data);
      request_type r;
      reply_type unused;
      int unsigned s;
      s = active_slots(plan_fifo);
      r.operation = op;
      r.amount = amt;
      r.write_bytes = data;
      if ((op == OP_DEQ || op == OP_PEEK) && amt <= LANES
          && amt <= stored_count(plan_fifo, s)) begin
         for (int i = 0; i < amt; i++)
            if (!plan_fifo.written[(plan_fifo.rd_ptr + i) % s]) r.operation = OP_ADVR;
      end
      fifo_step(plan_fifo, r, unused);
      pending_requests.push_back(r);
   endtask

   task automatic queue_random_request();
      int unsigned s, pick;
      logic [63:0] data;
      s = active_slots(plan_fifo);
      pick = $urandom_range(99);
      data = {$urandom, $urandom};
      if (pick < 40) queue_request(OP_ENQ, 13'($urandom_range(0, 8)), data);
      else if (pick < 68) queue_request(OP_DEQ, 13'($urandom_range(0, 8)), data);
      else if (pick < 80) queue_request(OP_PEEK, 13'($urandom_range(0, 8)), data);
      else if (pick < 86) queue_request(OP_ADVW, 13'($urandom_range(0, s + 1)), data);
      else if (pick < 92) queue_request(OP_ADVR, 13'($urandom_range(0, s + 1)), data);
      else if (pick < 94) queue_request(OP_CLEAR, 13'($urandom), data);
      else if (pick < 96)
         queue_request(3'($urandom_range(OP_SPARE_LO, OP_SPARE_HI)), 13'($urandom), data);
      else queue_request(3'($urandom_range(0, 7)), 13'($urandom), data);
   endtask

   task automatic wait_until_drained();
      @(negedge clock);
      while (pending_requests.size() != 0 || start || expected_replies.size() != 0)
         @(negedge clock);
      repeat (4) @(negedge clock);
   endtask

   task automatic write_size(logic [12:0] value);
      @(posedge clock);
      csr_write_enable <= 1'b1;
      csr_buffer_size <= value;
      @(posedge clock);
      csr_write_enable <= 1'b0;
      plan_fifo.size_reg = value;
      plan_fifo.rd_ptr = 0;
      plan_fifo.wr_ptr = 0;
      model_fifo.size_reg = value;
      model_fifo.rd_ptr = 0;
      model_fifo.wr_ptr = 0;
   endtask

   always @(posedge clock) begin
      request_type next;
      reply_type want;
      if (reset) begin
         start <= 1'b0;
      end else if (!(start && busy)) begin
         if (start) begin
            fifo_step(model_fifo, '{req_operation, req_amount, req_write_bytes}, want);
            expected_replies.push_back(want);
         end
         if (pending_requests.size() != 0 && $urandom_range(99) >= idle_percent) begin
            next = pending_requests.pop_front();
            start <= 1'b1;
            req_operation <= next.operation;
            req_amount <= next.amount;
            req_write_bytes <= next.write_bytes;
         end else begin
            start <= 1'b0;
         end
      end
   end

   always @(posedge clock) begin
      reply_type want;
      if (!reset && rsp_valid) begin
         if (expected_replies.size() == 0) begin
            $display("%0t: unexpected result, done_count %0d", $time, rsp_done_count);
            fail_count++;
         end else begin
            want = expected_replies.pop_front();
            if (rsp_done_count !== want.done_count) begin
               $display("%0t: done_count expected %0d actual %0d",
                        $time, want.done_count, rsp_done_count);
               fail_count++;
            end
            if (rsp_read_bytes !== want.read_bytes) begin
               $display("%0t: read_bytes expected %h actual %h",
                        $time, want.read_bytes, rsp_read_bytes);
               fail_count++;
            end
            if (rsp_used_size !== want.used_size) begin
               $display("%0t: used_size expected %0d actual %0d",
                        $time, want.used_size, rsp_used_size);
               fail_count++;
            end
            if (rsp_free_size !== want.free_size) begin
               $display("%0t: free_size expected %0d actual %0d",
                        $time, want.free_size, rsp_free_size);
               fail_count++;
            end
            if (rsp_direct_write_span !== want.direct_write_span) begin
               $display("%0t: direct_write_span expected %0d actual %0d",
                        $time, want.direct_write_span, rsp_direct_write_span);
               fail_count++;
            end
            if (rsp_direct_read_span !== want.direct_read_span) begin
               $display("%0t: direct_read_span expected %0d actual %0d",
                        $time, want.direct_read_span, rsp_direct_read_span);
               fail_count++;
            end
         end
      end
   end

   initial begin
      #2000000;
      $display("FAIL");
      $finish;
   end

   initial begin
      logic [12:0] sizes[10];
      foreach (plan_fifo.bytes[i]) begin
         plan_fifo.bytes[i] = '0;
         plan_fifo.written[i] = 1'b0;
      end
      plan_fifo.rd_ptr = 0;
      plan_fifo.wr_ptr = 0;
      plan_fifo.size_reg = 13'd4096;
      model_fifo = plan_fifo;
      repeat (3) @(posedge clock);
      reset <= 1'b0;

      idle_percent = 38;
      queue_request(OP_ENQ, 13'd0, '1);
      queue_request(OP_ENQ, 13'd8, '1);
      queue_request(OP_ENQ, 13'd8, '0);
      queue_request(OP_ENQ, 13'd9, '1);
      queue_request(OP_PEEK, 13'd8, '0);
      queue_request(OP_DEQ, 13'd8, '0);
      queue_request(OP_PEEK, 13'd9, '0);
      queue_request(OP_DEQ, 13'd8, '0);
      queue_request(OP_DEQ, 13'd1, '0);
      queue_request(OP_DEQ, 13'd0, '0);
      queue_request(OP_ADVW, 13'd4096, '0);
      queue_request(OP_ADVW, 13'd4097, '0);
      queue_request(OP_ADVR, 13'd4095, '0);
      queue_request(OP_ADVW, 13'd4090, '0);
      queue_request(OP_ENQ, 13'd8, 64'h0123_4567_89ab_cdef);
      queue_request(OP_DEQ, 13'd7, '0);
      queue_request(OP_ADVR, 13'h1fff, '0);
      queue_request(OP_CLEAR, 13'h1fff, '1);
      queue_request(OP_SPARE_LO, 13'd8, '1);
      queue_request(OP_SPARE_HI, 13'h1fff, '1);
      wait_until_drained();

      sizes = '{13'd0, 13'd1, 13'd2, 13'd3, 13'd9, 13'd17, 13'd4096, 13'h1fff,
                13'd40, 13'd4095};
      for (int seg = 0; seg < 10; seg++) begin
         idle_percent = (seg < 4) ? 38 : (seg < 7) ? 48 : 0;
         write_size((seg == 9) ? 13'($urandom_range(2, 4096)) : sizes[seg]);
         for (int n = 0; n < 93; n++) begin
            queue_random_request();
            if (seg == 5 && n == 46) wait_until_drained();
         end
         wait_until_drained();
      end

      if (fail_count == 0) begin
         $display("PASS");
      end else begin
         $display("FAIL");
      end
      $finish;
   end
endmodule

[files.f]
+incdir+rtl/core
rtl/core/brb_pkg.sv
rtl/core/brb_lane.sv
rtl/core/byte_ring_buffer_unit.sv
rtl/core/brb_checker.sv
tb/byte_ring_buffer_unit_tb.sv
